// ===== src/tme_pkg.sv =====
`timescale 1ns / 1ps

package tme_pkg;

  // Machine geometry
  localparam int STATE_COUNT       = 16;
  localparam int ENTRIES_PER_STATE = 8;
  localparam int TAPE_CELLS        = 1024;

  localparam int TBL_DEPTH = STATE_COUNT * ENTRIES_PER_STATE;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int TAPE_AW   = $clog2(TAPE_CELLS);
  localparam int KW        = (ENTRIES_PER_STATE > 1) ? $clog2(ENTRIES_PER_STATE) : 1;

  // Fixed field widths
  localparam int ACT_W   = 3;
  localparam int STATE_W = 4;
  localparam int SLOT_W  = 3;
  localparam int SYM_W   = 8;
  localparam int DIR_W   = 2;
  localparam int ADDR_W  = 10;
  localparam int CFG_IW  = 2;

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [STATE_W-1:0] mstate_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_START = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STEP  = 3'd4;

  // Head move codes; the spare code behaves as stay
  localparam logic [DIR_W-1:0] DIR_STAY  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ACCEPT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_REJECT = 2'd2;

  localparam mstate_t START_RST  = 4'd0;
  localparam mstate_t ACCEPT_RST = 4'd1;
  localparam mstate_t REJECT_RST = 4'd2;

  localparam sym_t BLANK = 8'h20;

  typedef struct packed {
    sym_t                match;
    mstate_t             next;
    logic [DIR_W-1:0]    dir;
    sym_t                wsym;
  } tme_entry_t;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [TBL_AW-1:0]   addr;
    logic                wvalid;
    tme_entry_t          wentry;
  } tbl_req_t;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [TAPE_AW-1:0]  addr;
    sym_t                wdata;
  } tape_req_t;

  typedef struct packed {
    mstate_t             mstate;
    addr_t               head;
    sym_t                sym;
    logic                acc;
    logic                rej;
    logic                nomatch;
    logic                edge_hit;
  } res_t;

endpackage

// ===== src/tme_table.sv =====
`timescale 1ns / 1ps

module tme_table import tme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  tbl_req_t   req,
  output tme_entry_t rd_entry,
  output logic       rd_valid
);

  tme_entry_t           mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wentry;
    end
    if (req.rd_en) begin
      rd_entry <= mem[req.addr];
    end
  end

  // Valid bits clear at reset so the whole table reads as unusable
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_bits[req.addr] <= req.wvalid;
      end
      if (req.rd_en) begin
        rd_valid <= valid_bits[req.addr];
      end
    end
  end

endmodule

// ===== src/tme_tape.sv =====
`timescale 1ns / 1ps

module tme_tape import tme_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tape_req_t req,
  output sym_t      rd_data,
  output logic      busy
);

  sym_t               mem [TAPE_CELLS];
  logic [TAPE_AW-1:0] clr_idx;
  logic               clr_active;
  logic               wr_en;
  logic [TAPE_AW-1:0] wr_addr;
  sym_t               wr_data;

  // Sweep blanks over every cell after reset, one cell a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + TAPE_AW'(1);
      if (32'(clr_idx) == TAPE_CELLS - 1) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en   = clr_active | req.wr_en;
    wr_addr = clr_active ? clr_idx : req.addr;
    wr_data = clr_active ? BLANK : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  assign busy = clr_active;

endmodule

// ===== src/tme_ctrl.sv =====
`timescale 1ns / 1ps

module tme_ctrl import tme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  mstate_t           state_index,
  input  logic [SLOT_W-1:0] slot,
  input  sym_t              match_symbol,
  input  mstate_t           next_state,
  input  logic [DIR_W-1:0]  move_dir,
  input  sym_t              write_symbol,
  input  logic              entry_valid,
  input  addr_t             cell_address,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  mstate_t           cfg_data,
  output tbl_req_t          tbl_req,
  input  tme_entry_t        tbl_entry,
  input  logic              tbl_valid,
  output tape_req_t         tape_req,
  input  sym_t              tape_data,
  input  logic              tape_busy,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_ready
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_APPLY    = 6'b001000,
    S_RDHEAD   = 6'b010000,
    S_FINISH   = 6'b100000
  } ctrl_state_t;

  ctrl_state_t       state, state_next;

  // Captured word
  logic [ACT_W-1:0]  act;
  mstate_t           sidx;
  logic [SLOT_W-1:0] eslot;
  sym_t              msym;
  mstate_t           nst;
  logic [DIR_W-1:0]  mdir;
  sym_t              wsym;
  logic              evalid;
  addr_t             addr;

  mstate_t           mstate;
  addr_t             head;
  mstate_t           start_q, accept_q, reject_q;
  logic [KW-1:0]     k;
  logic              nomatch_q, edge_q, blank_q;

  logic              in_accept;
  logic              halted, state_ok, load_ok, addr_ok, hit, last_k;
  logic [TBL_AW-1:0] load_addr, base_addr, scan_addr;

  assign in_stall  = (state != S_IDLE) || tape_busy;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    halted    = (mstate == accept_q) || (mstate == reject_q);
    state_ok  = 32'(mstate) < STATE_COUNT;
    load_ok   = (32'(sidx) < STATE_COUNT) && (32'(eslot) < ENTRIES_PER_STATE);
    addr_ok   = 32'(addr) < TAPE_CELLS;
    load_addr = TBL_AW'(32'(sidx) * ENTRIES_PER_STATE + 32'(eslot));
    base_addr = TBL_AW'(32'(mstate) * ENTRIES_PER_STATE);
    scan_addr = TBL_AW'(32'(mstate) * ENTRIES_PER_STATE + 32'(k) + 1);
    // Shared compare: one entry against the symbol under the head
    hit       = tbl_valid && (tbl_entry.match == tape_data);
    last_k    = 32'(k) == ENTRIES_PER_STATE - 1;
  end

  always_comb begin
    state_next = state;
    tbl_req    = '0;
    tape_req   = '0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_RDHEAD;
        case (act)
          ACT_LOAD: begin
            tbl_req.wr_en         = load_ok;
            tbl_req.addr          = load_addr;
            tbl_req.wvalid        = evalid;
            tbl_req.wentry.match  = msym;
            tbl_req.wentry.next   = nst;
            tbl_req.wentry.dir    = mdir;
            tbl_req.wentry.wsym   = wsym;
          end
          ACT_WRITE: begin
            tape_req.wr_en = addr_ok;
            tape_req.addr  = TAPE_AW'(addr);
            tape_req.wdata = wsym;
          end
          ACT_READ: begin
            tape_req.rd_en = 1'b1;
            tape_req.addr  = TAPE_AW'(addr);
            state_next     = S_FINISH;
          end
          ACT_STEP: begin
            if (!halted && state_ok) begin
              tape_req.rd_en = 1'b1;
              tape_req.addr  = TAPE_AW'(head);
              tbl_req.rd_en  = 1'b1;
              tbl_req.addr   = base_addr;
              state_next     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_APPLY;
        end else if (last_k) begin
          // tape data still holds the cell under the head
          state_next = S_FINISH;
        end else begin
          tbl_req.rd_en = 1'b1;
          tbl_req.addr  = scan_addr;
        end
      end
      S_APPLY: begin
        tape_req.wr_en = 1'b1;
        tape_req.addr  = TAPE_AW'(head);
        tape_req.wdata = tbl_entry.wsym;
        state_next     = S_RDHEAD;
      end
      S_RDHEAD: begin
        tape_req.rd_en = 1'b1;
        tape_req.addr  = TAPE_AW'(head);
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.mstate   = mstate;
    res.head     = head;
    res.sym      = blank_q ? BLANK : tape_data;
    res.acc      = mstate == accept_q;
    res.rej      = mstate == reject_q;
    res.nomatch  = nomatch_q;
    res.edge_hit = edge_q;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act    <= action;
      sidx   <= state_index;
      eslot  <= slot;
      msym   <= match_symbol;
      nst    <= next_state;
      mdir   <= move_dir;
      wsym   <= write_symbol;
      evalid <= entry_valid;
      addr   <= cell_address;
    end
    if (state == S_DISPATCH) begin
      k <= '0;
    end else if (state == S_SCAN && !hit && !last_k) begin
      k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mstate    <= '0;
      head      <= '0;
      start_q   <= START_RST;
      accept_q  <= ACCEPT_RST;
      reject_q  <= REJECT_RST;
      nomatch_q <= 1'b0;
      edge_q    <= 1'b0;
      blank_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START:  start_q  <= cfg_data;
          CFG_ACCEPT: accept_q <= cfg_data;
          CFG_REJECT: reject_q <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            nomatch_q <= 1'b0;
            edge_q    <= 1'b0;
            blank_q   <= 1'b0;
          end
        end
        S_DISPATCH: begin
          if (act == ACT_START) begin
            mstate <= start_q;
            head   <= addr_ok ? addr : ADDR_W'(TAPE_CELLS - 1);
          end
          if (act == ACT_READ) begin
            blank_q <= !addr_ok;
          end
          if (act == ACT_STEP && !halted && !state_ok) begin
            nomatch_q <= 1'b1;
          end
        end
        S_SCAN: begin
          if (!hit && last_k) begin
            nomatch_q <= 1'b1;
          end
        end
        S_APPLY: begin
          mstate <= tbl_entry.next;
          // Hold the head at either end of the tape and flag it
          if (tbl_entry.dir == DIR_LEFT) begin
            if (head == '0) begin
              edge_q <= 1'b1;
            end else begin
              head <= head - ADDR_W'(1);
            end
          end else if (tbl_entry.dir == DIR_RIGHT) begin
            if (32'(head) >= TAPE_CELLS - 1) begin
              edge_q <= 1'b1;
            end else begin
              head <= head + ADDR_W'(1);
            end
          end
        end
        S_RDHEAD, S_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_hit_applies: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |=> (state == S_APPLY))
    else $error("matching entry did not lead to apply");

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !hit && !last_k) |=> (state == S_SCAN && k == $past(k) + KW'(1)))
    else $error("scan did not advance to the next entry");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) < TAPE_CELLS)
    else $error("head left the tape");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    tape_busy |-> (state == S_IDLE && !tape_req.wr_en && !tape_req.rd_en))
    else $error("tape access during clearing pass");

endmodule

// ===== src/turing_machine_step_engine.sv =====
`timescale 1ns / 1ps

// Single-tape Turing machine step engine.
// Input channel (in_valid / in_stall): one word per action: load a transition
// entry, write or read a tape cell, start at a head cell, or take one step.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order: state, head, symbol under the head (read data for a read),
// accept/reject flags, and the no-match and edge flags of a step.
// Configuration (cfg_we / cfg_index / cfg_data): start, accept and reject
// state registers, to be written only while the engine is idle; the engine leaves this to the user.
// Load, write, start and halted steps go from dispatch through a head read
// to finish, and a read goes from dispatch to finish; a step scans its
// state's entries one per cycle through a single compare against the
// registered tape read, then applies a matching entry and rereads the head.
// One word is in flight at a time; in_stall is high until its result has
// moved into the output register, so a stalled receiver holds the engine.
// Reset clears the table's valid bits at once and then sweeps blanks over
// all TAPE_CELLS = 1024 tape cells, one cell per cycle, with in_stall
// high throughout.
module turing_machine_step_engine import tme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  mstate_t           state_index,
  input  logic [SLOT_W-1:0] slot,
  input  sym_t              match_symbol,
  input  mstate_t           next_state,
  input  logic [DIR_W-1:0]  move_dir,
  input  sym_t              write_symbol,
  input  logic              entry_valid,
  input  addr_t             cell_address,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  mstate_t           cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mstate_t           current_state,
  output addr_t             head_position,
  output sym_t              cell_symbol,
  output logic              halted_accept,
  output logic              halted_reject,
  output logic              no_match,
  output logic              edge_hit
);

  tbl_req_t   tbl_req;
  tme_entry_t tbl_entry;
  logic       tbl_valid;
  tape_req_t  tape_req;
  sym_t       tape_data;
  logic       tape_busy;
  logic       res_valid;
  logic       res_ready;
  res_t       res;

  tme_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_entry (tbl_entry),
    .rd_valid (tbl_valid)
  );

  tme_tape u_tape (
    .clk     (clk),
    .rst     (rst),
    .req     (tape_req),
    .rd_data (tape_data),
    .busy    (tape_busy)
  );

  tme_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .state_index  (state_index),
    .slot         (slot),
    .match_symbol (match_symbol),
    .next_state   (next_state),
    .move_dir     (move_dir),
    .write_symbol (write_symbol),
    .entry_valid  (entry_valid),
    .cell_address (cell_address),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tbl_req      (tbl_req),
    .tbl_entry    (tbl_entry),
    .tbl_valid    (tbl_valid),
    .tape_req     (tape_req),
    .tape_data    (tape_data),
    .tape_busy    (tape_busy),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  // Output register: take a new word when empty or when the held word leaves
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      current_state <= res.mstate;
      head_position <= res.head;
      cell_symbol   <= res.sym;
      halted_accept <= res.acc;
      halted_reject <= res.rej;
      no_match      <= res.nomatch;
      edge_hit      <= res.edge_hit;
    end
  end

endmodule

// ===== test/turing_machine_step_engine_test.sv =====
`timescale 1ns / 1ps

module turing_machine_step_engine_test;
  import tme_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_OFF_LEN   = 300;

  // Action codes the engine must pass through untouched
  localparam logic [ACT_W-1:0] ACT_UNUSED5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED7 = 3'd7;
  localparam logic [DIR_W-1:0] DIR_SPARE   = 2'd3;

  typedef struct {
    logic [ACT_W-1:0]  act;
    mstate_t           sidx;
    logic [SLOT_W-1:0] slot;
    sym_t              match;
    mstate_t           nxt;
    logic [DIR_W-1:0]  dir;
    sym_t              wsym;
    logic              ev;
    addr_t             addr;
  } tape_cmd_t;

  class tape_scoreboard;
    tme_entry_t entries [TBL_DEPTH];
    bit         usable  [TBL_DEPTH];
    sym_t       tape    [TAPE_CELLS];
    mstate_t    mstate;
    addr_t      head;
    mstate_t    start_r;
    mstate_t    accept_r;
    mstate_t    reject_r;
    res_t       expected_q [$];
    int         mismatches;

    function new();
      for (int i = 0; i < TBL_DEPTH; i++) begin
        entries[i] = '0;
        usable[i]  = 1'b0;
      end
      for (int i = 0; i < TAPE_CELLS; i++) tape[i] = BLANK;
      mstate     = '0;
      head       = '0;
      start_r    = START_RST;
      accept_r   = ACCEPT_RST;
      reject_r   = REJECT_RST;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IW-1:0] idx, mstate_t val);
      case (idx)
        CFG_START:  start_r  = val;
        CFG_ACCEPT: accept_r = val;
        CFG_REJECT: reject_r = val;
        default: ;
      endcase
    endfunction

    function bit halted();
      return mstate == accept_r || mstate == reject_r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the result word for one accepted command
    function void note_input(tape_cmd_t c);
      res_t r;
      int   idx;
      bit   found;
      bit   read_done;
      sym_t read_data;
      sym_t under;
      r         = '0;
      found     = 1'b0;
      read_done = 1'b0;
      read_data = BLANK;
      case (c.act)
        ACT_LOAD: begin
          idx                = int'(c.sidx) * ENTRIES_PER_STATE + int'(c.slot);
          entries[idx].match = c.match;
          entries[idx].next  = c.nxt;
          entries[idx].dir   = c.dir;
          entries[idx].wsym  = c.wsym;
          usable[idx]        = c.ev;
        end
        ACT_WRITE: tape[c.addr] = c.wsym;
        ACT_READ: begin
          read_done = 1'b1;
          read_data = tape[c.addr];
        end
        ACT_START: begin
          mstate = start_r;
          head   = c.addr;
        end
        ACT_STEP: begin
          if (!halted()) begin
            under = tape[head];
            for (int k = 0; k < ENTRIES_PER_STATE && !found; k++) begin
              idx = int'(mstate) * ENTRIES_PER_STATE + k;
              if (usable[idx] && entries[idx].match == under) begin
                found      = 1'b1;
                tape[head] = entries[idx].wsym;
                if (entries[idx].dir == DIR_LEFT) begin
                  if (head == 0) r.edge_hit = 1'b1;
                  else head = head - addr_t'(1);
                end else if (entries[idx].dir == DIR_RIGHT) begin
                  if (int'(head) == TAPE_CELLS - 1) r.edge_hit = 1'b1;
                  else head = head + addr_t'(1);
                end
                mstate = entries[idx].next;
              end
            end
            r.nomatch = !found;
          end
        end
        default: ;
      endcase
      r.mstate = mstate;
      r.head   = head;
      r.sym    = read_done ? read_data : tape[head];
      r.acc    = mstate == accept_r;
      r.rej    = mstate == reject_r;
      expected_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: state %0d head %0d sym %02h", got.mstate,
                   got.head, got.sym);
        return;
      end
      want = expected_q.pop_front();
      if (got.mstate !== want.mstate || got.head !== want.head || got.sym !== want.sym ||
          got.acc !== want.acc || got.rej !== want.rej || got.nomatch !== want.nomatch ||
          got.edge_hit !== want.edge_hit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected state %0d head %0d sym %02h acc %b rej %b nm %b edge %b",
                   want.mstate, want.head, want.sym, want.acc, want.rej, want.nomatch,
                   want.edge_hit);
          $display("          actual   state %0d head %0d sym %02h acc %b rej %b nm %b edge %b",
                   got.mstate, got.head, got.sym, got.acc, got.rej, got.nomatch,
                   got.edge_hit);
        end
      end
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  action       = '0;
  mstate_t           state_index  = '0;
  logic [SLOT_W-1:0] slot         = '0;
  sym_t              match_symbol = '0;
  mstate_t           next_state   = '0;
  logic [DIR_W-1:0]  move_dir     = '0;
  sym_t              write_symbol = '0;
  logic              entry_valid  = 1'b0;
  addr_t             cell_address = '0;
  logic              cfg_we       = 1'b0;
  logic [CFG_IW-1:0] cfg_index    = '0;
  mstate_t           cfg_data     = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  mstate_t           current_state;
  addr_t             head_position;
  sym_t              cell_symbol;
  logic              halted_accept;
  logic              halted_reject;
  logic              no_match;
  logic              edge_hit;

  tape_scoreboard sb = new();
  res_t           seen_word;
  int             idle_cycles  = 0;
  int             words_sent   = 0;
  int             hold_request = 0;
  bit             gaps_on      = 1'b1;
  bit             stall_on     = 1'b1;

  turing_machine_step_engine dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .state_index   (state_index),
    .slot          (slot),
    .match_symbol  (match_symbol),
    .next_state    (next_state),
    .move_dir      (move_dir),
    .write_symbol  (write_symbol),
    .entry_valid   (entry_valid),
    .cell_address  (cell_address),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .current_state (current_state),
    .head_position (head_position),
    .cell_symbol   (cell_symbol),
    .halted_accept (halted_accept),
    .halted_reject (halted_reject),
    .no_match      (no_match),
    .edge_hit      (edge_hit)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word.mstate   = current_state;
      seen_word.head     = head_position;
      seen_word.sym      = cell_symbol;
      seen_word.acc      = halted_accept;
      seen_word.rej      = halted_reject;
      seen_word.nomatch  = no_match;
      seen_word.edge_hit = edge_hit;
      sb.check_result(seen_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("turing_machine_step_engine_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = stall_on && ($urandom_range(99) < 9);
      end
    end
  end

  function automatic tape_cmd_t noise_cmd();
    tape_cmd_t c;
    c.act   = ACT_W'($urandom_range(0, 7));
    c.sidx  = mstate_t'($urandom);
    c.slot  = SLOT_W'($urandom);
    c.match = sym_t'($urandom);
    c.nxt   = mstate_t'($urandom);
    c.dir   = DIR_W'($urandom);
    c.wsym  = sym_t'($urandom);
    c.ev    = 1'($urandom);
    c.addr  = addr_t'($urandom);
    return c;
  endfunction

  // Entered and left just after a falling edge
  task automatic push_word(input tape_cmd_t c);
    if (gaps_on && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    action       = c.act;
    state_index  = c.sidx;
    slot         = c.slot;
    match_symbol = c.match;
    next_state   = c.nxt;
    move_dir     = c.dir;
    write_symbol = c.wsym;
    entry_valid  = c.ev;
    cell_address = c.addr;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(c);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic push_action(input logic [ACT_W-1:0] act);
    tape_cmd_t c;
    c     = noise_cmd();
    c.act = act;
    push_word(c);
  endtask

  task automatic load_entry(input mstate_t s, input logic [SLOT_W-1:0] k, input sym_t m,
                            input mstate_t n, input logic [DIR_W-1:0] d, input sym_t w,
                            input logic ev);
    tape_cmd_t c;
    c       = noise_cmd();
    c.act   = ACT_LOAD;
    c.sidx  = s;
    c.slot  = k;
    c.match = m;
    c.nxt   = n;
    c.dir   = d;
    c.wsym  = w;
    c.ev    = ev;
    push_word(c);
  endtask

  task automatic cell_access(input logic [ACT_W-1:0] act, input addr_t a, input sym_t s);
    tape_cmd_t c;
    c      = noise_cmd();
    c.act  = act;
    c.addr = a;
    c.wsym = s;
    push_word(c);
  endtask

  // Drop valid and wait for every outstanding result word
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic configure(input mstate_t s, input mstate_t a, input mstate_t r);
    cfg_we    = 1'b1;
    cfg_index = CFG_START;
    cfg_data  = s;
    @(posedge clk);
    sb.set_register(CFG_START, s);
    @(negedge clk);
    cfg_index = CFG_ACCEPT;
    cfg_data  = a;
    @(posedge clk);
    sb.set_register(CFG_ACCEPT, a);
    @(negedge clk);
    cfg_index = CFG_REJECT;
    cfg_data  = r;
    @(posedge clk);
    sb.set_register(CFG_REJECT, r);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load a small random machine over a tiny alphabet, seed the tape, start and run it
  task automatic run_program();
    mstate_t states [$];
    sym_t    alpha [3];
    addr_t   origin;
    mstate_t nxt;
    alpha[0] = BLANK;
    alpha[1] = sym_t'($urandom);
    alpha[2] = sym_t'($urandom);
    states.push_back(sb.start_r);
    repeat ($urandom_range(2, 4)) states.push_back(mstate_t'($urandom_range(0, 15)));
    foreach (states[i]) begin
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(99) < 80) begin
          if ($urandom_range(3) == 0) nxt = $urandom_range(1) ? sb.accept_r : sb.reject_r;
          else nxt = states[$urandom_range(0, states.size() - 1)];
          load_entry(states[i], SLOT_W'($urandom_range(0, 7)), alpha[j], nxt,
                     DIR_W'($urandom_range(0, 3)), alpha[$urandom_range(0, 2)],
                     $urandom_range(99) < 88);
        end
      end
    end
    case ($urandom_range(9))
      0:       origin = addr_t'($urandom_range(0, 3));
      1:       origin = addr_t'($urandom_range(TAPE_CELLS - 4, TAPE_CELLS - 1));
      default: origin = addr_t'($urandom_range(0, TAPE_CELLS - 1));
    endcase
    repeat ($urandom_range(3, 8))
      cell_access(ACT_WRITE, addr_t'(origin + $urandom_range(0, 6) - 3),
                  alpha[$urandom_range(0, 2)]);
    cell_access(ACT_START, origin, sym_t'($urandom));
    repeat ($urandom_range(15, 40)) begin
      case ($urandom_range(0, 19))
        0:       cell_access(ACT_READ, addr_t'(sb.head + $urandom_range(0, 4) - 2),
                             sym_t'($urandom));
        1:       push_word(noise_cmd());
        2:       cell_access(ACT_START, origin, sym_t'($urandom));
        default: push_action(ACT_STEP);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // hold off until the tape clearing sweep is done
    while (in_stall) @(negedge clk);
    configure(START_RST, ACCEPT_RST, REJECT_RST);

    // Empty table: first step finds nothing
    push_action(ACT_STEP);
    load_entry(4'd0, 3'd0, BLANK, 4'd3, DIR_LEFT, 8'hFF, 1'b1);
    load_entry(4'd0, 3'd1, BLANK, 4'd5, DIR_RIGHT, 8'h00, 1'b1);
    // left off cell zero: symbol written, head held
    push_action(ACT_STEP);
    cell_access(ACT_READ, 10'd0, 8'h00);
    load_entry(4'd3, 3'd7, 8'hFF, 4'd15, DIR_RIGHT, 8'h00, 1'b1);
    load_entry(4'd3, 3'd0, 8'hFF, 4'd9, DIR_LEFT, 8'h11, 1'b0);
    // invalid first entry is skipped, last slot fires
    push_action(ACT_STEP);
    cell_access(ACT_START, 10'd1023, 8'hFF);
    cell_access(ACT_WRITE, 10'd1023, 8'h00);
    load_entry(4'd0, 3'd2, 8'h00, 4'd15, DIR_RIGHT, 8'hAA, 1'b1);
    // right off the last cell
    push_action(ACT_STEP);
    load_entry(4'd15, 3'd3, 8'hAA, ACCEPT_RST, DIR_SPARE, 8'h55, 1'b1);
    push_action(ACT_STEP);
    // accepted machine holds still
    push_action(ACT_STEP);
    cell_access(ACT_READ, 10'd1023, 8'hFF);
    cell_access(ACT_WRITE, 10'd0, 8'hFF);
    push_action(ACT_UNUSED5);
    push_action(ACT_UNUSED6);
    push_action(ACT_UNUSED7);
    cell_access(ACT_START, 10'd512, 8'h00);
    push_action(ACT_STEP);
    push_action(ACT_STEP);
    load_entry(4'd3, 3'd4, BLANK, REJECT_RST, DIR_STAY, BLANK, 1'b1);
    push_action(ACT_STEP);
    push_action(ACT_STEP);
    while (words_sent < 320) run_program();

    drain();
    configure(4'd15, 4'd0, 4'd14);
    // long receiver hold-off while words keep coming
    hold_request = HOLD_OFF_LEN;
    while (words_sent < 620) run_program();

    drain();
    configure(4'd0, 4'd15, 4'd15);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (words_sent < 900) run_program();

    drain();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    configure(4'd7, 4'd7, 4'd3);
    while (words_sent < 960) run_program();

    drain();
    configure(4'd5, 4'd9, 4'd12);
    while (words_sent < 1030) run_program();

    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("turing_machine_step_engine_test passed");
    end else begin
      $display("turing_machine_step_engine_test failed");
    end
    $finish;
  end

endmodule
